// ===== src/srtc_pkg.sv =====
// Shared types and constants for the sample-rate to time-constant converter.
package srtc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_RATE = 2'd0,
        CFG_MAX_RATE = 2'd1,
        CFG_STEREO   = 2'd2
    } cfg_index_t;

    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] MIN_RATE_RESET = 16'd4000;
    localparam logic [CFG_W-1:0] MAX_RATE_RESET = 16'd44100;
    localparam logic [CFG_W-1:0] STEREO_LIMIT   = 16'd22050;

    // Divider geometry: 28-bit dividend, 16-bit divisor, 20-bit quotient
    localparam int DIV_NUM_W  = 28;
    localparam int DIV_DEN_W  = 16;
    localparam int DIV_QUO_W  = 20;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DIV_QUO_W / DIV_STEPS;

    localparam logic [DIV_NUM_W-1:0] HS_BASE   = 28'd256000000;
    localparam logic [DIV_NUM_W-1:0] NORM_BASE = 28'd1000000;

    localparam int TC_W   = 8;
    localparam int RATE_OUT_W = 20;

    typedef struct packed {
        logic stereo;
        logic hs;
        logic err;
    } flags_t;

    typedef struct packed {
        flags_t          flags;
        logic [TC_W-1:0] tc;
    } tc_tag_t;

    localparam int FLAGS_W  = $bits(flags_t);
    localparam int TC_TAG_W = $bits(tc_tag_t);

endpackage

// ===== src/srtc_if.sv =====
// Request and response channel interfaces.
interface srtc_req_if #(parameter int RATE_WIDTH = 24);
    logic                  valid;
    logic                  ready;
    logic [RATE_WIDTH-1:0] requested_rate;

    modport source (output valid, output requested_rate, input ready);
    modport sink   (input valid, input requested_rate, output ready);
endinterface

interface srtc_rsp_if;
    logic        valid;
    logic        ready;
    logic [19:0] actual_rate;
    logic [7:0]  time_constant;
    logic        high_speed;
    logic        rate_error;

    modport source (output valid, output actual_rate, output time_constant,
                    output high_speed, output rate_error, input ready);
    modport sink   (input valid, input actual_rate, input time_constant,
                    input high_speed, input rate_error, output ready);
endinterface

// ===== src/srtc_front.sv =====
// Front end: rate clamping, stereo doubling and dividend setup (two stages).
module srtc_front
    import srtc_pkg::*;
#(
    parameter int RATE_WIDTH = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [RATE_WIDTH-1:0] requested_rate,
    input  logic [CFG_W-1:0]      min_rate,
    input  logic [CFG_W-1:0]      max_rate,
    input  logic                  stereo_mode,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic [DIV_NUM_W-1:0]  dn_num,
    output logic [DIV_DEN_W-1:0]  dn_den,
    output flags_t                dn_flags
);

    // stage 1: clamp
    logic             s1_vld_reg;
    logic [CFG_W-1:0] s1_rate_reg;
    logic             s1_err_reg;
    logic             s1_stereo_reg;
    logic [CFG_W-1:0] s1_rate_next;
    logic             s1_err_next;
    logic             s1_ready;

    // stage 2: converter rate, path select, dividend
    logic                 s2_vld_reg;
    logic [DIV_NUM_W-1:0] s2_num_reg;
    logic [DIV_DEN_W-1:0] s2_den_reg;
    flags_t               s2_flags_reg;
    logic [DIV_DEN_W-1:0] cr;
    logic                 hs;
    logic [DIV_NUM_W-1:0] num_next;
    logic                 s2_ready;

    logic req_hi;
    logic below;
    logic above;

    assign s2_ready = !s2_vld_reg || dn_ready;
    assign s1_ready = !s1_vld_reg || s2_ready;
    assign up_ready = s1_ready;

    assign req_hi = |requested_rate[RATE_WIDTH-1:CFG_W];
    assign below  = !req_hi && (requested_rate[CFG_W-1:0] < min_rate);
    assign above  = req_hi || (requested_rate[CFG_W-1:0] > max_rate);

    always_comb
    begin
        // min is tested first, so min above max gives min for low requests
        priority if (below)
        begin
            s1_rate_next = min_rate;
            s1_err_next  = 1'b1;
        end
        else if (above)
        begin
            s1_rate_next = max_rate;
            s1_err_next  = 1'b1;
        end
        else
        begin
            s1_rate_next = requested_rate[CFG_W-1:0];
            s1_err_next  = 1'b0;
        end
        if (stereo_mode && (s1_rate_next > STEREO_LIMIT))
        begin
            s1_rate_next = STEREO_LIMIT;
            s1_err_next  = 1'b1;
        end
        // a zero limit would give a zero divisor
        if (s1_rate_next == '0)
        begin
            s1_rate_next = CFG_W'(1);
            s1_err_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_rate_reg   <= s1_rate_next;
            s1_err_reg    <= s1_err_next;
            s1_stereo_reg <= stereo_mode;
        end
    end

    // stereo rate is at most 22050, so doubling fits 16 bits
    assign cr       = s1_stereo_reg ? {s1_rate_reg[CFG_W-2:0], 1'b0} : s1_rate_reg;
    assign hs       = cr > STEREO_LIMIT;
    assign num_next = (hs ? HS_BASE : NORM_BASE) + DIV_NUM_W'(cr[DIV_DEN_W-1:1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_vld_reg)
        begin
            s2_num_reg          <= num_next;
            s2_den_reg          <= cr;
            s2_flags_reg.stereo <= s1_stereo_reg;
            s2_flags_reg.hs     <= hs;
            s2_flags_reg.err    <= s1_err_reg;
        end
    end

    assign dn_valid = s2_vld_reg;
    assign dn_num   = s2_num_reg;
    assign dn_den   = s2_den_reg;
    assign dn_flags = s2_flags_reg;

endmodule

// ===== src/srtc_div.sv =====
// Pipelined restoring divider, a few quotient bits per stage.
module srtc_div
    import srtc_pkg::*;
#(
    parameter int TAG_W = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [DIV_NUM_W-1:0] up_num,
    input  logic [DIV_DEN_W-1:0] up_den,
    input  logic [TAG_W-1:0]     up_tag,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic [DIV_QUO_W-1:0] dn_quo,
    output logic [TAG_W-1:0]     dn_tag
);

    // index 0 is the input, index s+1 the register of stage s
    logic [DIV_STAGES:0]  st_valid;
    logic [DIV_STAGES:0]  st_ready;
    logic [DIV_DEN_W-1:0] st_rem [DIV_STAGES+1];
    logic [DIV_QUO_W-1:0] st_nq  [DIV_STAGES+1];
    logic [DIV_DEN_W-1:0] st_den [DIV_STAGES+1];
    logic [TAG_W-1:0]     st_tag [DIV_STAGES+1];

    // dividend is below den * 2^20, so its top bits start below den
    assign st_valid[0] = up_valid;
    assign st_rem[0]   = DIV_DEN_W'(up_num[DIV_NUM_W-1:DIV_QUO_W]);
    assign st_nq[0]    = up_num[DIV_QUO_W-1:0];
    assign st_den[0]   = up_den;
    assign st_tag[0]   = up_tag;

    assign st_ready[DIV_STAGES] = dn_ready;
    assign up_ready             = st_ready[0];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic                 vld_reg;
        logic [DIV_DEN_W-1:0] rem_reg;
        logic [DIV_QUO_W-1:0] nq_reg;
        logic [DIV_DEN_W-1:0] den_reg;
        logic [TAG_W-1:0]     tag_reg;
        logic [DIV_DEN_W-1:0] rem_next;
        logic [DIV_QUO_W-1:0] nq_next;

        assign st_ready[s] = !vld_reg || st_ready[s+1];

        // nq: dividend bits shift out the top, quotient bits shift in below
        always_comb
        begin : step
            logic [DIV_DEN_W:0] trial;
            logic [DIV_DEN_W:0] diff;
            rem_next = st_rem[s];
            nq_next  = st_nq[s];
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                trial    = {rem_next, nq_next[DIV_QUO_W-1]};
                diff     = trial - {1'b0, st_den[s]};
                nq_next  = {nq_next[DIV_QUO_W-2:0], !diff[DIV_DEN_W]};
                rem_next = diff[DIV_DEN_W] ? trial[DIV_DEN_W-1:0] : diff[DIV_DEN_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (st_ready[s])
            begin
                vld_reg <= st_valid[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (st_ready[s] && st_valid[s])
            begin
                rem_reg <= rem_next;
                nq_reg  <= nq_next;
                den_reg <= st_den[s];
                tag_reg <= st_tag[s];
            end
        end

        assign st_valid[s+1] = vld_reg;
        assign st_rem[s+1]   = rem_reg;
        assign st_nq[s+1]    = nq_reg;
        assign st_den[s+1]   = den_reg;
        assign st_tag[s+1]   = tag_reg;
    end

    assign dn_valid = st_valid[DIV_STAGES];
    assign dn_quo   = st_nq[DIV_STAGES];
    assign dn_tag   = st_tag[DIV_STAGES];

endmodule

// ===== src/srtc_tcalc.sv =====
// Time constant byte from the quotient, and dividend for the rate work-back.
module srtc_tcalc
    import srtc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [DIV_QUO_W-1:0] quo,
    input  flags_t               flags,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic [DIV_NUM_W-1:0] dn_num,
    output logic [DIV_DEN_W-1:0] dn_den,
    output tc_tag_t              dn_tag
);

    logic                 vld_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    tc_tag_t              tag_reg;

    logic [15:0]     neg_q;
    logic [TC_W-1:0] tc_next;
    logic [TC_W:0]   span;

    // high speed: upper byte of 65536 - q; normal: 256 - q mod 256
    assign neg_q   = 16'd0 - quo[15:0];
    assign tc_next = flags.hs ? neg_q[15:8] : neg_q[7:0];

    // both paths work back as round(1000000 / (256 - tc))
    assign span = 9'd256 - {1'b0, tc_next};

    assign up_ready = !vld_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            num_reg       <= NORM_BASE + DIV_NUM_W'(span[TC_W:1]);
            den_reg       <= DIV_DEN_W'(span);
            tag_reg.flags <= flags;
            tag_reg.tc    <= tc_next;
        end
    end

    assign dn_valid = vld_reg;
    assign dn_num   = num_reg;
    assign dn_den   = den_reg;
    assign dn_tag   = tag_reg;

endmodule

// ===== src/srtc_out.sv =====
// Output register: stereo halving and the response word.
module srtc_out
    import srtc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [DIV_QUO_W-1:0]  quo,
    input  tc_tag_t               tag,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic [RATE_OUT_W-1:0] actual_rate,
    output logic [TC_W-1:0]       time_constant,
    output logic                  high_speed,
    output logic                  rate_error
);

    logic                  vld_reg;
    logic [RATE_OUT_W-1:0] rate_reg;
    logic [TC_W-1:0]       tc_reg;
    logic                  hs_reg;
    logic                  err_reg;
    logic [RATE_OUT_W-1:0] rate_next;

    assign rate_next = tag.flags.stereo ? RATE_OUT_W'(quo >> 1) : RATE_OUT_W'(quo);
    assign up_ready  = !vld_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rate_reg <= rate_next;
            tc_reg   <= tag.tc;
            hs_reg   <= tag.flags.hs;
            err_reg  <= tag.flags.err;
        end
    end

    assign dn_valid      = vld_reg;
    assign actual_rate   = rate_reg;
    assign time_constant = tc_reg;
    assign high_speed    = hs_reg;
    assign rate_error    = err_reg;

endmodule

// ===== src/sample_rate_to_time_constant.sv =====
// Top level of the sample-rate to time-constant converter.
//
// Each request word carries a sample rate in hertz. The rate is clamped to
// min_rate (tested first), then max_rate, and in stereo to 22050 Hz; a zero
// result is forced to 1 Hz. Any clamp sets rate_error. In stereo the
// converter runs at twice the channel rate. Converter rates above 22050 Hz
// use the high-speed path (upper byte of 65536 - round(256e6 / rate)),
// others the normal path ((256 - round(1e6 / rate)) mod 256). The achieved
// rate is worked back from the byte, halved in stereo, and returned with the
// byte and both flags, one response word per request, in order.
// Throughput is one word per clock while the receiver holds ready high. A
// word passes 14 registers (2 front-end stages, two 5-stage dividers, one
// time-constant stage, one output stage): the edge that takes a request
// loads the first of them, and the word moves on through the others in
// that order up to the response register. Most of the latency comes from
// the two 20-bit-quotient dividers, which resolve 4 quotient bits per stage.
// Every stage has its own valid bit and ready is chained backward, so
// bubbles are squeezed out and a request is taken while a finished word
// waits.
// Configuration (index 0 min_rate, 1 max_rate, 2 stereo_mode; others ignored)
// should be written only while the pipeline is empty.
module sample_rate_to_time_constant
    import srtc_pkg::*;
#(
    parameter int RATE_WIDTH = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    srtc_req_if.sink             req,
    srtc_rsp_if.source           rsp
);

    // configuration registers
    logic [CFG_W-1:0] min_rate_reg;
    logic [CFG_W-1:0] max_rate_reg;
    logic             stereo_mode_reg;

    // front end -> first divider
    logic                 fe_valid;
    logic                 fe_ready;
    logic [DIV_NUM_W-1:0] fe_num;
    logic [DIV_DEN_W-1:0] fe_den;
    flags_t               fe_flags;

    // first divider -> time constant stage
    logic                 qa_valid;
    logic                 qa_ready;
    logic [DIV_QUO_W-1:0] qa_quo;
    logic [FLAGS_W-1:0]   qa_tag;
    flags_t               qa_flags;

    // time constant stage -> second divider
    logic                 tc_valid;
    logic                 tc_ready;
    logic [DIV_NUM_W-1:0] tc_num;
    logic [DIV_DEN_W-1:0] tc_den;
    tc_tag_t              tc_tag;

    // second divider -> output register
    logic                 qb_valid;
    logic                 qb_ready;
    logic [DIV_QUO_W-1:0] qb_quo;
    logic [TC_TAG_W-1:0]  qb_tag;
    tc_tag_t              qb_tag_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rate_reg    <= MIN_RATE_RESET;
            max_rate_reg    <= MAX_RATE_RESET;
            stereo_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_RATE: min_rate_reg    <= cfg_data;
                CFG_MAX_RATE: max_rate_reg    <= cfg_data;
                CFG_STEREO:   stereo_mode_reg <= cfg_data[0];
                default:      ;  // unused index, write dropped
            endcase
        end
    end

    // clamp and dividend setup
    srtc_front #(
        .RATE_WIDTH (RATE_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (req.valid),
        .up_ready       (req.ready),
        .requested_rate (req.requested_rate),
        .min_rate       (min_rate_reg),
        .max_rate       (max_rate_reg),
        .stereo_mode    (stereo_mode_reg),
        .dn_valid       (fe_valid),
        .dn_ready       (fe_ready),
        .dn_num         (fe_num),
        .dn_den         (fe_den),
        .dn_flags       (fe_flags)
    );

    // round(base / converter rate)
    srtc_div #(
        .TAG_W (FLAGS_W)
    ) u_div_tc (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (fe_valid),
        .up_ready (fe_ready),
        .up_num   (fe_num),
        .up_den   (fe_den),
        .up_tag   (fe_flags),
        .dn_valid (qa_valid),
        .dn_ready (qa_ready),
        .dn_quo   (qa_quo),
        .dn_tag   (qa_tag)
    );

    assign qa_flags = qa_tag;

    srtc_tcalc u_tcalc (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (qa_valid),
        .up_ready (qa_ready),
        .quo      (qa_quo),
        .flags    (qa_flags),
        .dn_valid (tc_valid),
        .dn_ready (tc_ready),
        .dn_num   (tc_num),
        .dn_den   (tc_den),
        .dn_tag   (tc_tag)
    );

    // round(1e6 / (256 - tc)): achieved converter rate
    srtc_div #(
        .TAG_W (TC_TAG_W)
    ) u_div_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (tc_valid),
        .up_ready (tc_ready),
        .up_num   (tc_num),
        .up_den   (tc_den),
        .up_tag   (tc_tag),
        .dn_valid (qb_valid),
        .dn_ready (qb_ready),
        .dn_quo   (qb_quo),
        .dn_tag   (qb_tag)
    );

    assign qb_tag_s = qb_tag;

    srtc_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (qb_valid),
        .up_ready      (qb_ready),
        .quo           (qb_quo),
        .tag           (qb_tag_s),
        .dn_valid      (rsp.valid),
        .dn_ready      (rsp.ready),
        .actual_rate   (rsp.actual_rate),
        .time_constant (rsp.time_constant),
        .high_speed    (rsp.high_speed),
        .rate_error    (rsp.rate_error)
    );

    // high-speed bytes stay within the band reachable from 22051..65535 Hz
    a_hs_tc_band: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.high_speed) |->
            (rsp.time_constant >= 8'd210 && rsp.time_constant <= 8'd240))
        else $error("high-speed time constant out of band");

    // achieved rate is never zero and never above 1 MHz
    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.actual_rate != '0 && rsp.actual_rate <= 20'd1000000))
        else $error("achieved rate out of range");

    // high-speed achieved rate is at least 1e6/46, halved in stereo
    a_hs_rate_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.high_speed) |-> (rsp.actual_rate >= 20'd10869))
        else $error("high-speed achieved rate too low");

endmodule

// ===== tb/tb_sample_rate_to_time_constant.sv =====
// Self-checking testbench for the sample-rate to time-constant converter.
module tb_sample_rate_to_time_constant;
    timeunit 1ns;
    timeprecision 1ps;

    import srtc_pkg::*;

    localparam int RATE_W         = 24;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 4;
    // Slack at the end to let the pipe settle.
    localparam int PIPE_SETTLE    = 30;
    // Cycles with no word moving on either channel before we give up.
    localparam int STUCK_LIMIT    = 2000;
    // Receiver hold-off long enough to back the whole pipe up into the input.
    localparam int LONG_HOLD      = 80;
    localparam int PRESSURE_WORDS = 60;
    localparam int PHASES         = 13;
    localparam int PHASE_WORDS    = 45;

    // Divider bases and limits of the converter, kept at 32 bits here
    localparam int unsigned FAST_BASE  = 256000000;
    localparam int unsigned SLOW_BASE  = 1000000;
    localparam int unsigned FAST_SPAN  = 65536;
    localparam int unsigned STEREO_CAP = 22050;

    // Index 3 is not a register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [RATE_OUT_W-1:0] actual_rate;
        logic [TC_W-1:0]       time_constant;
        logic                  high_speed;
        logic                  rate_error;
    } tc_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    srtc_req_if #(.RATE_WIDTH(RATE_W)) req ();
    srtc_rsp_if                        rsp ();

    // Our own copy of the register file, updated on every write we issue
    logic [CFG_W-1:0] lim_lo;
    logic [CFG_W-1:0] lim_hi;
    logic             stereo_on;

    tc_word_t    tc_expect_q[$];
    int unsigned mismatches    = 0;
    bit          req_idling    = 1'b1;
    bit          rsp_idling    = 1'b1;
    int unsigned hold_requests = 0;

    sample_rate_to_time_constant #(.RATE_WIDTH(RATE_W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Unsigned division rounded to nearest, ties up.
    function automatic int unsigned round_quot(input int unsigned num,
                                               input int unsigned den);
        return (num + den / 2) / den;
    endfunction

    // Expected response word for one request under the current registers.
    function automatic tc_word_t predict_word(input logic [RATE_W-1:0] rate_hz);
        int unsigned req_hz;
        int unsigned lo;
        int unsigned hi;
        int unsigned rate;
        int unsigned quot;
        int unsigned tc;
        int unsigned period;
        int unsigned got;
        tc_word_t    w;
        req_hz       = 32'(rate_hz);
        lo           = 32'(lim_lo);
        hi           = 32'(lim_hi);
        w.rate_error = 1'b0;
        // Minimum is tested first, so crossed limits give min_rate for low requests.
        if (req_hz < lo)
        begin
            rate = lo;
            w.rate_error = 1'b1;
        end
        else if (req_hz > hi)
        begin
            rate = hi;
            w.rate_error = 1'b1;
        end
        else
        begin
            rate = req_hz;
        end
        if (stereo_on && rate > STEREO_CAP)
        begin
            rate = STEREO_CAP;
            w.rate_error = 1'b1;
        end
        // A limit written as zero can leave nothing to divide by.
        if (rate == 0)
        begin
            rate = 1;
            w.rate_error = 1'b1;
        end
        if (stereo_on)
            rate = rate * 2;
        if (rate > STEREO_CAP)
        begin
            // High-speed path: only the upper byte of the 16-bit constant
            quot         = round_quot(FAST_BASE, rate);
            tc           = ((FAST_SPAN - quot) >> 8) & 32'hff;
            period       = FAST_SPAN - (tc << 8);
            got          = round_quot(FAST_BASE, period);
            w.high_speed = 1'b1;
        end
        else
        begin
            // Normal path: wraps modulo 256 for very slow rates
            quot         = round_quot(SLOW_BASE, rate);
            tc           = (32'd256 - quot) & 32'hff;
            period       = 32'd256 - tc;
            got          = round_quot(SLOW_BASE, period);
            w.high_speed = 1'b0;
        end
        if (stereo_on)
            got = got / 2;
        w.actual_rate   = got[RATE_OUT_W-1:0];
        w.time_constant = tc[TC_W-1:0];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random request biased toward the clamp edges and path boundary.
    function automatic logic [RATE_W-1:0] random_rate();
        int near;
        near = 0;
        case ($urandom_range(0, 7))
            0:       return RATE_W'($urandom);
            1, 2:    return RATE_W'($urandom_range(0, 70000));
            3:       near = int'(lim_lo) + int'($urandom_range(0, 4)) - 2;
            4:       near = int'(lim_hi) + int'($urandom_range(0, 4)) - 2;
            5:       near = int'($urandom_range(0, 1) ? STEREO_CAP : STEREO_CAP / 2)
                            + int'($urandom_range(0, 4)) - 2;
            default: return RATE_W'($urandom_range(32'(lim_lo), 32'(lim_hi)));
        endcase
        return (near < 0) ? '0 : RATE_W'(near);
    endfunction

    // One register write; write enable is low again before the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_MIN_RATE: lim_lo    = value;
            CFG_MAX_RATE: lim_hi    = value;
            CFG_STEREO:   stereo_on = value[0];
            default:      ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one request word, hold it until taken, then log its prediction.
    // ready is sampled at the falling edge, where it is settled for the
    // rising edge that follows.
    task automatic send_rate(input logic [RATE_W-1:0] rate_hz);
        int unsigned gap;
        bit          taken;
        gap = (req_idling && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.requested_rate <= rate_hz;
        do
        begin
            @(negedge clk);
            taken = req.ready;
            @(posedge clk);
        end while (!taken);
        tc_expect_q.push_back(predict_word(rate_hz));
    endtask

    // Stop offering and wait for every outstanding response word.
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (tc_expect_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset limits (4000..44100, mono): clamp edges, path edge, field extremes.
    task automatic test_default_limits();
        logic [RATE_W-1:0] picks[] = '{24'd0, 24'd3999, 24'd4000, 24'd22050,
                                       24'd22051, 24'd44100, 24'd44101,
                                       24'hFFFFFF, 24'd11025};
        foreach (picks[i])
            send_rate(picks[i]);
    endtask

    // Stereo caps the channel rate at 22050 and doubles the converter rate.
    task automatic test_stereo_cap();
        logic [RATE_W-1:0] picks[] = '{24'd22050, 24'd22051, 24'd11025,
                                       24'd4000, 24'd0, 24'hFFFFFF};
        wait_drained();
        write_reg(CFG_STEREO, 16'd1);
        foreach (picks[i])
            send_rate(picks[i]);
    endtask

    // min above max: low requests land on min_rate, high ones on max_rate.
    // Also a write to the unused index, which must change nothing.
    task automatic test_crossed_limits();
        wait_drained();
        write_reg(CFG_MIN_RATE, 16'd30000);
        write_reg(CFG_MAX_RATE, 16'd5000);
        write_reg(CFG_STEREO, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_rate(24'd100);
        send_rate(24'd20000);
        send_rate(24'd40000);
    endtask

    // Zero limits force 1 Hz; very slow normal-path rates wrap the byte.
    task automatic test_zero_and_slow_rates();
        logic [RATE_W-1:0] picks[] = '{24'd1, 24'd2, 24'd3, 24'd255,
                                       24'd3907, 24'd65535};
        wait_drained();
        write_reg(CFG_MIN_RATE, 16'd0);
        write_reg(CFG_MAX_RATE, 16'd0);
        send_rate(24'd0);
        send_rate(24'd7);
        wait_drained();
        write_reg(CFG_MIN_RATE, 16'd1);
        write_reg(CFG_MAX_RATE, 16'hFFFF);
        foreach (picks[i])
            send_rate(picks[i]);
    endtask

    // Receiver goes quiet for a long stretch while requests keep coming, so
    // the pipe fills and ready drops at the input; then drain completely.
    task automatic test_output_backpressure();
        wait_drained();
        write_reg(CFG_MIN_RATE, 16'd1);
        write_reg(CFG_MAX_RATE, 16'hFFFF);
        write_reg(CFG_STEREO, 16'd0);
        req_idling = 1'b0;
        rsp_idling = 1'b0;
        @(negedge clk);
        hold_requests++;
        @(posedge clk);
        repeat (PRESSURE_WORDS)
            send_rate(random_rate());
        wait_drained();
    endtask

    // Random requests under a series of register settings, extremes first.
    task automatic test_random_phases();
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [CFG_W-1:0] st_word;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            // Random upper bits on the stereo write; only bit 0 counts.
            st_word = CFG_W'($urandom);
            case (phase)
                0:
                begin
                    lo = 16'd1;
                    hi = 16'hFFFF;
                    st_word[0] = 1'b0;
                end
                1:
                begin
                    lo = 16'd1;
                    hi = 16'hFFFF;
                    st_word[0] = 1'b1;
                end
                2:
                begin
                    lo = 16'hFFFF;
                    hi = 16'hFFFF;
                    st_word[0] = 1'b0;
                end
                3:
                begin
                    lo = 16'hFFFF;
                    hi = 16'd1;
                    st_word[0] = 1'b1;
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        lo = CFG_W'($urandom);
                        hi = CFG_W'($urandom);
                    end
                    else
                    begin
                        lo = CFG_W'($urandom_range(1, 12000));
                        hi = CFG_W'($urandom_range(32'(lo), 32'hFFFF));
                    end
                end
            endcase
            write_reg(CFG_MIN_RATE, lo);
            write_reg(CFG_MAX_RATE, hi);
            write_reg(CFG_STEREO, st_word);
            // Some phases run back to back with no idling at all.
            req_idling = (phase % 3 != 0);
            rsp_idling = (phase % 4 != 1);
            repeat (PHASE_WORDS)
                send_rate(random_rate());
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: ready generator and checker
    // ------------------------------------------------------------------

    // Random stalls, plus the long hold-off when a test asks for one.
    initial
    begin : rsp_ready_gen
        int unsigned quiet;
        int unsigned holds_seen;
        quiet      = 0;
        holds_seen = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                quiet      = LONG_HOLD;
            end
            else if (quiet == 0 && rsp_idling && $urandom_range(0, 3) == 0)
            begin
                quiet = pick_gap();
            end
            if (quiet != 0)
            begin
                rsp.ready <= 1'b0;
                quiet--;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, field, want, got);
        end
    endtask

    // Compare each response word with the oldest prediction. Sampled at the
    // falling edge, ahead of the rising edge that takes the word.
    always @(negedge clk)
    begin : rsp_check
        tc_word_t want;
        if (rsp.valid && rsp.ready)
        begin
            if (tc_expect_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word, expected none, got rate %0d tc %0d",
                         $time, rsp.actual_rate, rsp.time_constant);
            end
            else
            begin
                want = tc_expect_q.pop_front();
                check_field("actual_rate", 32'(want.actual_rate),
                            32'(rsp.actual_rate));
                check_field("time_constant", 32'(want.time_constant),
                            32'(rsp.time_constant));
                check_field("high_speed", 32'(want.high_speed),
                            32'(rsp.high_speed));
                check_field("rate_error", 32'(want.rate_error),
                            32'(rsp.rate_error));
            end
        end
    end

    // Watchdog: ends the run if no word moves for too long.
    initial
    begin : stall_watch
        int unsigned stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(negedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("** sample_rate_to_time_constant: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : run_tests
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        req.valid          <= 1'b0;
        req.requested_rate <= '0;
        lim_lo    = MIN_RATE_RESET;
        lim_hi    = MAX_RATE_RESET;
        stereo_on = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_limits();
        test_stereo_cap();
        test_crossed_limits();
        test_zero_and_slow_rates();
        test_output_backpressure();
        test_random_phases();

        wait_drained();
        // Let anything stray fall out of the pipe before judging.
        repeat (PIPE_SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("** sample_rate_to_time_constant: PASSED **");
        else
            $display("** sample_rate_to_time_constant: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
src/srtc_pkg.sv
src/srtc_if.sv
src/srtc_front.sv
src/srtc_div.sv
src/srtc_tcalc.sv
src/srtc_out.sv
src/sample_rate_to_time_constant.sv
tb/tb_sample_rate_to_time_constant.sv
